@@ rtl/sbq_pkg.sv @@
// ----------------------------------------------------------------------------
// sbq_pkg
// shared types and constants of the shaped biquad filter unit
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int DELAY_W = 40;
    localparam int ACC_W   = 54;
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
    localparam int TAB_W   = 32;
    localparam int FRAC_W  = 30;
    localparam int WET_W   = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [CFG_IDX_W-1:0] CFG_B0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WET = 3'd5;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ADDR  = 7'b0000010,
        ST_TAB0  = 7'b0000100,
        ST_TAB1  = 7'b0001000,
        ST_START = 7'b0010000,
        ST_MUL   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        OP_SIN  = 4'd0,
        OP_B0   = 4'd1,
        OP_B1   = 4'd2,
        OP_A1   = 4'd3,
        OP_B2   = 4'd4,
        OP_A2   = 4'd5,
        OP_ASIN = 4'd6,
        OP_WET  = 4'd7,
        OP_DRY  = 4'd8
    } op_t;

endpackage

@@ rtl/shaped_biquad_filter_unit.sv @@
// ----------------------------------------------------------------------------
// shaped_biquad_filter_unit
// sine shaping, transposed direct form ii biquad, arcsine shaping, wet mix
// ----------------------------------------------------------------------------
// One sample is processed at a time, using the shared bit-serial multiplier
// for every product: a start, 32 shift-add steps and a done strobe. There are
// seven products, or nine when mixing is active (wet_mix below one). Each of
// the two table lookups passes through the ST_ADDR, ST_TAB0 and ST_TAB1
// states, and the output and idle states follow. The result sits in an output
// register, so a new sample is taken as soon as the previous one is finished.
// Coefficient writes are taken at any time and must be made while idle.
module shaped_biquad_filter_unit #(
    parameter int SAMPLE_BITS       = 24,
    parameter int COEF_FRAC_BITS    = 28,
    parameter int SHAPE_TABLE_DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sbq_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sbq_pkg::CFG_DAT_W-1:0]          cfg_data
);

    localparam int DW  = sbq_pkg::DELAY_W;
    localparam int AW  = sbq_pkg::ACC_W;
    localparam int IW  = $clog2(SHAPE_TABLE_DEPTH + 1);
    localparam int PW  = sbq_pkg::FRAC_W + IW + 1;
    localparam int DRY_SHL = (SAMPLE_BITS <= 31) ? 31 - SAMPLE_BITS : 0;
    localparam int DRY_SHR = (SAMPLE_BITS > 31) ? 1 : 0;
    localparam logic signed [AW-1:0] DMAX = AW'((64'sd1 <<< (DW - 1)) - 1);
    localparam logic signed [AW-1:0] DMIN = -AW'(64'sd1 <<< (DW - 1));
    localparam logic signed [AW-1:0] ONE_Q30 = AW'(64'sd1 <<< 30);
    localparam logic signed [AW:0] SMAX = (AW + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [AW:0] SMIN = -SMAX - 1;
    localparam logic signed [sbq_pkg::WET_W:0] WET_ONE = 19'sd65536;

    sbq_pkg::state_t state_reg, state_next;
    sbq_pkg::op_t    op_reg, op_next;

    logic signed [31:0]     dry_reg, dry_next;
    logic [30:0]            v_reg, v_next;
    logic                   neg_reg, neg_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [sbq_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic [sbq_pkg::TAB_W-1:0]  t0_reg, t0_next;
    logic signed [31:0]     s_reg, s_next;
    logic signed [DW-1:0]   temp_reg, temp_next;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic signed [AW-1:0]   p_reg, p_next;
    logic signed [DW-1:0]   d1_reg, d1_next, d2_reg, d2_next;
    logic signed [31:0]     b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [sbq_pkg::WET_W-1:0] wet_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;

    logic [IW-1:0]          rom_addr;
    logic [sbq_pkg::TAB_W-1:0] sin_data, asin_data, rom_data;
    logic                   mul_start, mul_busy, mul_done;
    logic signed [sbq_pkg::MUL_A_W-1:0] mul_a;
    logic signed [sbq_pkg::MUL_B_W-1:0] mul_b;
    logic signed [sbq_pkg::MUL_P_W-1:0] mul_p;

    logic signed [32:0]     x_ext, dry_full;
    logic [PW-1:0]          pos;
    logic signed [AW-1:0]   ps, lk, shaped, sum, y;
    logic signed [sbq_pkg::MUL_P_W-1:0] p_shift;
    logic signed [sbq_pkg::WET_W:0] aw_wet, dry_gain;
    logic signed [AW:0]     r_full;

    function automatic logic signed [DW-1:0] sat_delay(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = (v > DMAX) ? DMAX : ((v < DMIN) ? DMIN : v);
        return c[DW-1:0];
    endfunction

    sbq_shape_rom #(.DEPTH(SHAPE_TABLE_DEPTH), .IS_ASIN(1'b0)) u_sin_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (sin_data)
    );

    sbq_shape_rom #(.DEPTH(SHAPE_TABLE_DEPTH), .IS_ASIN(1'b1)) u_asin_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (asin_data)
    );

    sbq_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (mul_p)
    );

    assign s_ready   = (state_reg == sbq_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_sample_out = out_reg;
    assign mul_start = (state_reg == sbq_pkg::ST_START);
    assign rom_data  = (op_reg == sbq_pkg::OP_ASIN) ? asin_data : sin_data;

    always_comb begin
        if (state_reg == sbq_pkg::ST_TAB0 || idx_reg == IW'(SHAPE_TABLE_DEPTH)) begin
            rom_addr = idx_reg;
        end else begin
            rom_addr = idx_reg + 1'b1;
        end
    end

    always_comb begin
        aw_wet   = wet_reg[sbq_pkg::WET_W-1] ? -(sbq_pkg::WET_W + 1)'(wet_reg)
                                            : (sbq_pkg::WET_W + 1)'(wet_reg);
        dry_gain = WET_ONE - aw_wet;
        case (op_reg)
            sbq_pkg::OP_SIN, sbq_pkg::OP_ASIN: begin
                mul_a = sbq_pkg::MUL_A_W'($signed({1'b0, rom_data}) - $signed({1'b0, t0_reg}));
                mul_b = sbq_pkg::MUL_B_W'({1'b0, frac_reg});
            end
            sbq_pkg::OP_B0: begin
                mul_a = sbq_pkg::MUL_A_W'(s_reg);
                mul_b = b0_reg;
            end
            sbq_pkg::OP_B1: begin
                mul_a = sbq_pkg::MUL_A_W'(s_reg);
                mul_b = b1_reg;
            end
            sbq_pkg::OP_A1: begin
                mul_a = temp_reg;
                mul_b = a1_reg;
            end
            sbq_pkg::OP_B2: begin
                mul_a = sbq_pkg::MUL_A_W'(s_reg);
                mul_b = b2_reg;
            end
            sbq_pkg::OP_A2: begin
                mul_a = temp_reg;
                mul_b = a2_reg;
            end
            sbq_pkg::OP_WET: begin
                mul_a = p_reg[sbq_pkg::MUL_A_W-1:0];
                mul_b = sbq_pkg::MUL_B_W'(wet_reg);
            end
            sbq_pkg::OP_DRY: begin
                mul_a = sbq_pkg::MUL_A_W'(dry_reg);
                mul_b = sbq_pkg::MUL_B_W'(dry_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        case (op_reg)
            sbq_pkg::OP_SIN, sbq_pkg::OP_ASIN: p_shift = mul_p >>> 30;
            sbq_pkg::OP_WET, sbq_pkg::OP_DRY:  p_shift = mul_p;
            default:                           p_shift = mul_p >>> COEF_FRAC_BITS;
        endcase
        ps = p_shift[AW-1:0];
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        dry_next   = dry_reg;
        v_next     = v_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        frac_next  = frac_reg;
        t0_next    = t0_reg;
        s_next     = s_reg;
        temp_next  = temp_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        out_next   = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        x_ext    = (33)'(s_sample_in);
        dry_full = (x_ext <<< DRY_SHL) >>> DRY_SHR;
        pos      = PW'(v_reg) * PW'(SHAPE_TABLE_DEPTH);
        lk       = AW'($signed({1'b0, t0_reg})) + ps;
        shaped   = neg_reg ? -lk : lk;
        sum      = acc_reg + ps;
        y        = (AW'(temp_reg) > ONE_Q30) ? ONE_Q30
                 : ((AW'(temp_reg) < -ONE_Q30) ? -ONE_Q30 : AW'(temp_reg));
        r_full   = (SAMPLE_BITS <= 31) ? ((AW + 1)'(p_reg) >>> DRY_SHL)
                                       : ((AW + 1)'(p_reg) <<< 1);

        case (state_reg)
            sbq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    dry_next   = dry_full[31:0];
                    v_next     = dry_full[32] ? 31'(-dry_full) : 31'(dry_full);
                    neg_next   = dry_full[32];
                    op_next    = sbq_pkg::OP_SIN;
                    state_next = sbq_pkg::ST_ADDR;
                end
            end
            sbq_pkg::ST_ADDR: begin
                if (pos[PW-1:sbq_pkg::FRAC_W] >= (IW + 1)'(SHAPE_TABLE_DEPTH)) begin
                    idx_next  = IW'(SHAPE_TABLE_DEPTH);
                    frac_next = '0;
                end else begin
                    idx_next  = pos[sbq_pkg::FRAC_W +: IW];
                    frac_next = pos[sbq_pkg::FRAC_W-1:0];
                end
                state_next = sbq_pkg::ST_TAB0;
            end
            sbq_pkg::ST_TAB0: begin
                state_next = sbq_pkg::ST_TAB1;
            end
            sbq_pkg::ST_TAB1: begin
                t0_next    = rom_data;
                state_next = sbq_pkg::ST_START;
            end
            sbq_pkg::ST_START: begin
                state_next = sbq_pkg::ST_MUL;
            end
            sbq_pkg::ST_MUL: begin
                if (mul_done) begin
                    state_next = sbq_pkg::ST_START;
                    case (op_reg)
                        sbq_pkg::OP_SIN: begin
                            s_next  = shaped[31:0];
                            op_next = sbq_pkg::OP_B0;
                        end
                        sbq_pkg::OP_B0: begin
                            temp_next = sat_delay(ps + AW'(d1_reg));
                            op_next   = sbq_pkg::OP_B1;
                        end
                        sbq_pkg::OP_B1: begin
                            acc_next = ps + AW'(d2_reg);
                            op_next  = sbq_pkg::OP_A1;
                        end
                        sbq_pkg::OP_A1: begin
                            d1_next = sat_delay(acc_reg - ps);
                            op_next = sbq_pkg::OP_B2;
                        end
                        sbq_pkg::OP_B2: begin
                            acc_next = ps;
                            op_next  = sbq_pkg::OP_A2;
                        end
                        sbq_pkg::OP_A2: begin
                            d2_next    = sat_delay(acc_reg - ps);
                            v_next     = y[AW-1] ? 31'(-y) : 31'(y);
                            neg_next   = y[AW-1];
                            op_next    = sbq_pkg::OP_ASIN;
                            state_next = sbq_pkg::ST_ADDR;
                        end
                        sbq_pkg::OP_ASIN: begin
                            p_next = shaped;
                            if ((sbq_pkg::WET_W + 1)'(wet_reg) < WET_ONE) begin
                                op_next = sbq_pkg::OP_WET;
                            end else begin
                                state_next = sbq_pkg::ST_OUT;
                            end
                        end
                        sbq_pkg::OP_WET: begin
                            acc_next = ps;
                            op_next  = sbq_pkg::OP_DRY;
                        end
                        sbq_pkg::OP_DRY: begin
                            p_next     = sum >>> 16;
                            state_next = sbq_pkg::ST_OUT;
                        end
                        default: begin
                            state_next = sbq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            sbq_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next = (r_full > SMAX) ? SAMPLE_BITS'(SMAX)
                             : ((r_full < SMIN) ? SAMPLE_BITS'(SMIN)
                                                : r_full[SAMPLE_BITS-1:0]);
                    m_valid_next = 1'b1;
                    state_next   = sbq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbq_pkg::ST_IDLE;
            op_reg      <= sbq_pkg::OP_SIN;
            m_valid_reg <= 1'b0;
            d1_reg      <= '0;
            d2_reg      <= '0;
            b0_reg      <= '0;
            b1_reg      <= '0;
            b2_reg      <= '0;
            a1_reg      <= '0;
            a2_reg      <= '0;
            wet_reg     <= 18'sd65536;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            if (cfg_valid) begin
                case (cfg_index)
                    sbq_pkg::CFG_B0:  b0_reg  <= cfg_data;
                    sbq_pkg::CFG_B1:  b1_reg  <= cfg_data;
                    sbq_pkg::CFG_B2:  b2_reg  <= cfg_data;
                    sbq_pkg::CFG_A1:  a1_reg  <= cfg_data;
                    sbq_pkg::CFG_A2:  a2_reg  <= cfg_data;
                    sbq_pkg::CFG_WET: wet_reg <= cfg_data[sbq_pkg::WET_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        dry_reg  <= dry_next;
        v_reg    <= v_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        frac_reg <= frac_next;
        t0_reg   <= t0_next;
        s_reg    <= s_next;
        temp_reg <= temp_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_mul_busy_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_busy |-> state_reg == sbq_pkg::ST_MUL)
        else $error("multiplier busy outside multiply state");
    a_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == sbq_pkg::ST_MUL)
        else $error("multiplier done outside multiply state");
    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sbq_pkg::ST_OUT && m_valid_reg && !m_ready)
        |=> state_reg == sbq_pkg::ST_OUT)
        else $error("result overwritten before taken");
`endif

endmodule

@@ rtl/sbq_serial_mult.sv @@
// ----------------------------------------------------------------------------
// sbq_serial_mult
// signed shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module sbq_serial_mult (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [sbq_pkg::MUL_A_W-1:0]  a,
    input  logic signed [sbq_pkg::MUL_B_W-1:0]  b,
    output logic                                busy,
    output logic                                done,
    output logic signed [sbq_pkg::MUL_P_W-1:0]  prod
);

    localparam int AW = sbq_pkg::MUL_A_W;
    localparam int BW = sbq_pkg::MUL_B_W;
    localparam int CW = $clog2(BW);

    logic signed [AW-1:0] a_reg;
    logic        [AW:0]   hi_reg, hi_next;
    logic        [BW-1:0] lo_reg, lo_next;
    logic        [CW-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [AW+1:0] ext_a, addend, sum;
    logic                 last;

    always_comb begin
        last    = (cnt_reg == CW'(BW - 1));
        ext_a   = (AW + 2)'(a_reg);
        addend  = lo_reg[0] ? (last ? -ext_a : ext_a) : '0;
        sum     = $signed({hi_reg[AW], hi_reg}) + addend;
        hi_next = hi_reg;
        lo_next = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum[AW+1:1];
            lo_next  = {sum[0], lo_reg[BW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        if (start) begin
            a_reg <= a;
        end
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = $signed({hi_reg, lo_reg});

endmodule

@@ rtl/sbq_shape_rom.sv @@
// ----------------------------------------------------------------------------
// sbq_shape_rom
// sine or arcsine table over [0,1] in Q30, registered read
// ----------------------------------------------------------------------------
module sbq_shape_rom #(
    parameter int DEPTH   = 256,
    parameter bit IS_ASIN = 1'b0
) (
    input  logic                          aclk,
    input  logic [$clog2(DEPTH+1)-1:0]    addr,
    output logic [sbq_pkg::TAB_W-1:0]     data
);

    typedef logic [sbq_pkg::TAB_W-1:0] rom_t [0:DEPTH];

    function automatic logic signed [63:0] series_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic signed [63:0] sum;
        x2  = (x * x) >> 30;
        t   = x;
        sum = $signed(x);
        for (int n = 1; n <= 10; n++) begin
            t = (t * x2) >> 30;
            case (n)
                1:       t = t / 64'd6;
                2:       t = t / 64'd20;
                3:       t = t / 64'd42;
                4:       t = t / 64'd72;
                5:       t = t / 64'd110;
                6:       t = t / 64'd156;
                7:       t = t / 64'd210;
                8:       t = t / 64'd272;
                9:       t = t / 64'd342;
                default: t = t / 64'd420;
            endcase
            if (n % 2 == 1) sum = sum - $signed(t);
            else sum = sum + $signed(t);
        end
        return sum;
    endfunction

    function automatic rom_t build_tab();
        rom_t tab;
        logic [63:0] g, lo, hi, mid;
        logic signed [63:0] v;
        for (int k = 0; k <= DEPTH; k++) begin
            g = (64'(k) << 30) / DEPTH;
            if (IS_ASIN) begin
                lo = '0;
                hi = sbq_pkg::HALF_PI_Q30;
                for (int i = 0; i < 31; i++) begin
                    mid = (lo + hi) >> 1;
                    if (series_sin(mid) < $signed(g)) lo = mid;
                    else hi = mid;
                end
                tab[k] = hi[sbq_pkg::TAB_W-1:0];
            end else begin
                v = series_sin(g);
                tab[k] = v[sbq_pkg::TAB_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam rom_t TAB = build_tab();

    logic [sbq_pkg::TAB_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= TAB[addr];
    end

    assign data = data_reg;

endmodule
